[sv/shn_pkg.sv]
// Package for the height-to-normal block: item types passed between the
// front, queue and back parts. No dependencies.
`default_nettype none
package shn_pkg;

  typedef struct packed {
    logic [19:0] gx2;
    logic [19:0] gy2;
    logic [31:0] z2;
    logic [9:0]  gx_mag;
    logic        gx_neg;
    logic [9:0]  gy_mag;
    logic        gy_neg;
    logic [15:0] z;
  } grad_t;

  localparam int SQ_STEPS = 27;
  localparam int LEN_W    = 27;
  localparam int REM_W    = 29;
  localparam int S_W      = 38;

endpackage
`default_nettype wire

[sv/shn_front.sv]
// Front part: forms the Sobel gradients and their squares in two stages.
// Depends on shn_pkg.
`default_nettype none
module shn_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [63:0]  in_data,
  input  wire logic [15:0]  flat_z,
  output logic              push_valid,
  input  wire logic         push_ready,
  output shn_pkg::grad_t    push_item
);
  import shn_pkg::*;

  logic               va_r, vb_r;
  logic signed [10:0] gx_r, gy_r;
  logic [15:0]        za_r;
  grad_t              item_r;
  logic               adv;
  logic signed [10:0] gx_nxt, gy_nxt;
  logic [10:0]        ul, u, ur, ml, mr, dl, d, dr;
  logic [9:0]         gxm, gym;

  assign ul = {3'b0, in_data[7:0]};
  assign u  = {3'b0, in_data[15:8]};
  assign ur = {3'b0, in_data[23:16]};
  assign ml = {3'b0, in_data[31:24]};
  assign mr = {3'b0, in_data[39:32]};
  assign dl = {3'b0, in_data[47:40]};
  assign d  = {3'b0, in_data[55:48]};
  assign dr = {3'b0, in_data[63:56]};

  assign gx_nxt = $signed(ur + (mr << 1) + dr - ul - (ml << 1) - dl);
  assign gy_nxt = $signed(dl + (d << 1) + dr - ul - (u << 1) - ur);
  assign gxm    = gx_r[10] ? 10'(-gx_r) : gx_r[9:0];
  assign gym    = gy_r[10] ? 10'(-gy_r) : gy_r[9:0];

  assign adv        = !vb_r || push_ready;
  assign in_ready   = adv;
  assign push_valid = vb_r;
  assign push_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      za_r <= (flat_z == 16'd0) ? 16'd1 : flat_z;
      item_r.gx2    <= 20'(gxm * gxm);
      item_r.gy2    <= 20'(gym * gym);
      item_r.z2     <= 32'(za_r * za_r);
      item_r.gx_mag <= gxm;
      item_r.gx_neg <= gx_r[10];
      item_r.gy_mag <= gym;
      item_r.gy_neg <= gy_r[10];
      item_r.z      <= za_r;
    end
  end
endmodule
`default_nettype wire

[sv/shn_fifo.sv]
// Four-entry queue between the front and back parts.
// Depends on shn_pkg.
`default_nettype none
module shn_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire shn_pkg::grad_t push_item,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output shn_pkg::grad_t    pop_item
);
  import shn_pkg::*;

  grad_t       mem_r [4];
  logic [1:0]  wr_r, rd_r;
  logic [2:0]  cnt_r;
  logic        push, pop;

  assign push_ready = (cnt_r != 3'd4);
  assign pop_valid  = (cnt_r != 3'd0);
  assign pop_item   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wr_r <= wr_r + 2'd1;
      if (pop)  rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end
endmodule
`default_nettype wire

[sv/shn_back.sv]
// Back part: square root pipeline, three restoring dividers and byte mapping.
// Depends on shn_pkg.
`default_nettype none
module shn_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire shn_pkg::grad_t pop_item,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [31:0]         out_tdata
);
  import shn_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int DW  = LEN_W + 1;
  localparam int TW  = FRAC_BITS + 10;

  logic adv;

  logic                  sv_r    [SQ_STEPS+1];
  logic [S_W-1:0]        ss_r    [SQ_STEPS+1];
  logic [LEN_W-1:0]      sroot_r [SQ_STEPS+1];
  logic [REM_W-1:0]      srem_r  [SQ_STEPS+1];
  logic [9:0]            sxm_r   [SQ_STEPS+1];
  logic                  sxn_r   [SQ_STEPS+1];
  logic [9:0]            sym_r   [SQ_STEPS+1];
  logic                  syn_r   [SQ_STEPS+1];
  logic [15:0]           sz_r    [SQ_STEPS+1];

  logic                  dv_r   [QW+1];
  logic [LEN_W-1:0]      dlen_r [QW+1];
  logic [DW-1:0]         drem_r [3][QW+1];
  logic [QW-1:0]         dq_r   [3][QW+1];
  logic                  dxn_r  [QW+1];
  logic                  dyn_r  [QW+1];

  logic                  out_valid_r;
  logic [31:0]           out_data_r;

  assign adv        = !out_valid_r || out_tready;
  assign pop_ready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r[0]    <= ({S_W{1'b0}} | ((S_W'(pop_item.gx2) + S_W'(pop_item.gy2)) << 16))
                    + S_W'(pop_item.z2);
      sroot_r[0] <= '0;
      srem_r[0]  <= '0;
      sxm_r[0]   <= pop_item.gx_mag;
      sxn_r[0]   <= pop_item.gx_neg;
      sym_r[0]   <= pop_item.gy_mag;
      syn_r[0]   <= pop_item.gy_neg;
      sz_r[0]    <= pop_item.z;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam int P = SQ_STEPS - 1 - i;
    logic [1:0]       pair;
    logic [REM_W-1:0] r2, trial;
    if (P >= 8) begin : g_pair
      assign pair = ss_r[i][2*P-15:2*P-16];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    assign r2    = {srem_r[i][REM_W-3:0], pair};
    assign trial = {sroot_r[i], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i+1] <= 1'b0;
      end else if (adv) begin
        sv_r[i+1] <= sv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (r2 >= trial) begin
          srem_r[i+1]  <= r2 - trial;
          sroot_r[i+1] <= {sroot_r[i][LEN_W-2:0], 1'b1};
        end else begin
          srem_r[i+1]  <= r2;
          sroot_r[i+1] <= {sroot_r[i][LEN_W-2:0], 1'b0};
        end
        ss_r[i+1]  <= ss_r[i];
        sxm_r[i+1] <= sxm_r[i];
        sxn_r[i+1] <= sxn_r[i];
        sym_r[i+1] <= sym_r[i];
        syn_r[i+1] <= syn_r[i];
        sz_r[i+1]  <= sz_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= sv_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dlen_r[0]    <= sroot_r[SQ_STEPS];
      drem_r[0][0] <= DW'({sxm_r[SQ_STEPS], 15'b0});
      drem_r[1][0] <= DW'({sym_r[SQ_STEPS], 15'b0});
      drem_r[2][0] <= DW'({sz_r[SQ_STEPS], 7'b0});
      dq_r[0][0]   <= '0;
      dq_r[1][0]   <= '0;
      dq_r[2][0]   <= '0;
      dxn_r[0]     <= sxn_r[SQ_STEPS];
      dyn_r[0]     <= syn_r[SQ_STEPS];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [DW-1:0] r2;
      assign r2 = {drem_r[k][j][DW-2:0], 1'b0};
      always_ff @(posedge clk) begin
        if (adv) begin
          if (r2 >= DW'(dlen_r[j])) begin
            drem_r[k][j+1] <= r2 - DW'(dlen_r[j]);
            dq_r[k][j+1]   <= {dq_r[k][j][QW-2:0], 1'b1};
          end else begin
            drem_r[k][j+1] <= r2;
            dq_r[k][j+1]   <= {dq_r[k][j][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dlen_r[j+1] <= dlen_r[j];
        dxn_r[j+1]  <= dxn_r[j];
        dyn_r[j+1]  <= dyn_r[j];
      end
    end
  end

  function automatic logic [7:0] to_byte(input logic [QW-1:0] q, input logic neg);
    logic [TW-1:0] base, prod, t;
    logic [TW-1:0] b;
    base = TW'(1) << (FRAC_BITS + 8);
    prod = (TW'(q) << 8) - TW'(q);
    if (neg) begin
      t = (prod >= base) ? '0 : base - prod;
    end else begin
      t = base + prod;
    end
    b = t >> (FRAC_BITS + 1);
    return (b > TW'(255)) ? 8'hFF : b[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {8'hFF, to_byte(dq_r[0][QW], dxn_r[QW]),
                     to_byte(dq_r[1][QW], dyn_r[QW]), to_byte(dq_r[2][QW], 1'b0)};
    end
  end
endmodule
`default_nettype wire

[sv/sobel_height_to_normal.sv]
// Top level: Sobel height window to packed normal word.
// Depends on shn_pkg, shn_front, shn_fifo and shn_back.
//
//   channel | ports                               | word
//   input   | in_tvalid, in_tready, in_tdata      | eight 8-bit heights
//   output  | out_tvalid, out_tready, out_tdata   | packed ARGB normal
//   config  | cfg_valid, cfg_ready, cfg_data      | flat_z_q8
//
// One word is taken per cycle while the front is not stalled by a full queue.
// A word passes through two front stages, the queue, the square root entry
// register, 27 square root steps, the divider entry register, FRAC_BITS + 1
// divider steps, the output register and the output handshake. Reset is
// synchronous, active low, and restores flat_z_q8 to 65280. The front and
// back stall independently through the four-word queue.
`default_nettype none
module sobel_height_to_normal #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // h_up_left, h_up, h_up_right, h_mid_left, h_mid_right, h_down_left,
  // h_down, h_down_right
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // normal_word
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import shn_pkg::*;

  logic [15:0] flat_z_r;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  grad_t       push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flat_z_r <= 16'd65280;
    end else if (cfg_valid && cfg_ready) begin
      flat_z_r <= cfg_data;
    end
  end

  shn_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .flat_z(flat_z_r),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
  );

  shn_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
  );

  shn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule
`default_nettype wire
